// ===== hw/rtl/blzss_pkg.sv =====
package blzss_pkg;

    localparam int WINDOW_BYTES_DEF = 2048;
    localparam int CMD_DEPTH_DEF    = 4;
    localparam int OUT_DEPTH_DEF    = 4;

    localparam int DIST_W    = 11;
    localparam int CNT_W     = 6;
    localparam int MATCH_MIN = 3;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_AFTER_DONE = 2'd1;
    localparam logic [1:0] ERR_EARLY_END  = 2'd2;

    typedef enum logic [1:0] {
        OP_FILL = 2'd0,
        OP_COPY = 2'd1,
        OP_ERR  = 2'd2
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [7:0]        value;
        logic [CNT_W-1:0]  count;
        logic [DIST_W-1:0] dist_m1;
        logic              done;
        logic [1:0]        err;
    } cmd_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
        logic [1:0] err;
    } res_t;

endpackage

// ===== hw/rtl/blzss_ram.sv =====
module blzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/blzss_fifo.sv =====
module blzss_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic                       full,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = slot_reg[rptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/blzss_front.sv =====
module blzss_front
    import blzss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       cmd_push,
    output cmd_t       cmd
);

    typedef enum logic [10:0] {
        PH_SZ0       = 11'b000_0000_0001,
        PH_SZ1       = 11'b000_0000_0010,
        PH_SZ2       = 11'b000_0000_0100,
        PH_SZ3       = 11'b000_0000_1000,
        PH_HDR0      = 11'b000_0001_0000,
        PH_HDR1      = 11'b000_0010_0000,
        PH_STORED    = 11'b000_0100_0000,
        PH_TOKEN     = 11'b000_1000_0000,
        PH_AFTERFLAG = 11'b001_0000_0000,
        PH_MATCH2    = 11'b010_0000_0000,
        PH_DONE      = 11'b100_0000_0000
    } phase_t;

    phase_t        phase_reg;
    phase_t        phase_next;
    logic [31:0]   size_reg;
    logic [31:0]   size_next;
    logic [31:0]   remain_reg;
    logic [31:0]   remain_next;
    logic [14:0]   left_reg;
    logic [14:0]   left_next;
    logic [15:0]   pos_reg;
    logic [15:0]   pos_next;
    logic [7:0]    first_reg;
    logic [7:0]    first_next;
    logic [15:0]   flag_reg;
    logic [15:0]   flag_next;
    logic [7:0]    held_reg;
    logic [7:0]    held_next;

    always_comb
    begin
        logic [15:0]       word;
        logic [15:0]       fs;
        logic              tok;
        logic              tok_bit;
        logic              lit;
        logic              mat;
        logic              body;
        logic              pre_start;
        logic [CNT_W-1:0]  put_cnt;
        logic [CNT_W-1:0]  n_emit;
        logic [DIST_W-1:0] dist_m1;
        logic [16:0]       pos_sum;
        logic [1:0]        err;

        phase_next  = phase_reg;
        size_next   = size_reg;
        remain_next = remain_reg;
        left_next   = left_reg;
        pos_next    = pos_reg;
        first_next  = first_reg;
        flag_next   = flag_reg;
        held_next   = held_reg;
        word        = {held_reg, in_byte};
        fs          = {1'b0, flag_reg[15:1]};
        tok         = 1'b0;
        tok_bit     = 1'b0;
        lit         = 1'b0;
        mat         = 1'b0;
        pre_start   = 1'b0;
        put_cnt     = '0;
        n_emit      = '0;
        dist_m1     = word[15:5];
        pos_sum     = '0;
        err         = ERR_NONE;
        cmd         = '0;
        cmd_push    = 1'b0;
        body        = phase_reg inside {PH_STORED, PH_TOKEN, PH_AFTERFLAG, PH_MATCH2};

        unique case (phase_reg) inside
            PH_DONE:
            begin
                err = ERR_AFTER_DONE;
            end
            PH_SZ0, PH_SZ1, PH_SZ2:
            begin
                size_next  = {size_reg[23:0], in_byte};
                phase_next = (phase_reg == PH_SZ0) ? PH_SZ1 :
                             (phase_reg == PH_SZ1) ? PH_SZ2 : PH_SZ3;
            end
            PH_SZ3:
            begin
                size_next   = {size_reg[23:0], in_byte};
                remain_next = {size_reg[23:0], in_byte};
                phase_next  = ({size_reg[23:0], in_byte} == '0) ? PH_DONE : PH_HDR0;
            end
            PH_HDR0:
            begin
                held_next  = in_byte;
                phase_next = PH_HDR1;
            end
            PH_HDR1:
            begin
                left_next  = word[14:0];
                pos_next   = '0;
                first_next = '0;
                flag_next  = '0;
                phase_next = word[15] ? PH_STORED : PH_TOKEN;
                if (word[14:0] == '0)
                begin
                    phase_next = (remain_reg == '0) ? PH_DONE : PH_HDR0;
                end
            end
            PH_STORED:
            begin
                lit = 1'b1;
            end
            PH_TOKEN:
            begin
                if (!fs[8])
                begin
                    flag_next  = {8'hff, in_byte};
                    phase_next = PH_AFTERFLAG;
                end
                else
                begin
                    flag_next = fs;
                    tok       = 1'b1;
                    tok_bit   = fs[0];
                end
            end
            PH_AFTERFLAG:
            begin
                tok     = 1'b1;
                tok_bit = flag_reg[0];
            end
            PH_MATCH2:
            begin
                mat = 1'b1;
            end
            default:
            begin
                err = ERR_NONE;
            end
        endcase

        if (tok)
        begin
            if (tok_bit)
            begin
                held_next  = in_byte;
                phase_next = PH_MATCH2;
            end
            else
            begin
                lit        = 1'b1;
                phase_next = PH_TOKEN;
            end
        end

        if (lit)
        begin
            put_cnt = CNT_W'(1);
            if (pos_reg == '0)
            begin
                first_next = in_byte;
            end
        end

        if (mat)
        begin
            put_cnt    = CNT_W'(word[4:0]) + CNT_W'(MATCH_MIN);
            pre_start  = ({5'b0, dist_m1} >= pos_reg);
            phase_next = PH_TOKEN;
        end

        if (lit || mat)
        begin
            pos_sum  = {1'b0, pos_reg} + 17'(put_cnt);
            pos_next = pos_sum[16] ? 16'hffff : pos_sum[15:0];
        end

        if (body)
        begin
            n_emit      = (remain_reg < 32'(put_cnt)) ? remain_reg[CNT_W-1:0] : put_cnt;
            remain_next = remain_reg - 32'(n_emit);
            left_next   = left_reg - 1'b1;
            if (left_reg == 15'd1)
            begin
                phase_next = (remain_next == '0) ? PH_DONE : PH_HDR0;
            end
        end

        if (err == ERR_NONE && in_last && phase_next != PH_DONE)
        begin
            err = ERR_EARLY_END;
        end

        if (err != ERR_NONE)
        begin
            cmd.op    = OP_ERR;
            cmd.count = CNT_W'(1);
            cmd.done  = (err == ERR_AFTER_DONE);
            cmd.err   = err;
            cmd_push  = accept;
        end
        else
        begin
            cmd.op      = (mat && !pre_start) ? OP_COPY : OP_FILL;
            cmd.value   = mat ? first_reg : in_byte;
            cmd.count   = n_emit;
            cmd.dist_m1 = dist_m1;
            cmd.done    = (phase_next == PH_DONE);
            cmd.err     = ERR_NONE;
            cmd_push    = accept && (n_emit != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SZ0;
            size_reg   <= '0;
            remain_reg <= '0;
            left_reg   <= '0;
            pos_reg    <= '0;
            first_reg  <= '0;
            flag_reg   <= '0;
            held_reg   <= '0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                phase_reg  <= PH_SZ0;
                size_reg   <= '0;
                remain_reg <= '0;
                left_reg   <= '0;
                pos_reg    <= '0;
                first_reg  <= '0;
                flag_reg   <= '0;
                held_reg   <= '0;
            end
            else
            begin
                phase_reg  <= phase_next;
                size_reg   <= size_next;
                remain_reg <= remain_next;
                left_reg   <= left_next;
                pos_reg    <= pos_next;
                first_reg  <= first_next;
                flag_reg   <= flag_next;
                held_reg   <= held_next;
            end
        end
    end

endmodule

// ===== hw/rtl/blzss_back.sv =====
module blzss_back
    import blzss_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
    parameter int OUT_DEPTH    = OUT_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_empty,
    input  cmd_t                           cmd_head,
    output logic                           cmd_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                           out_push,
    output res_t                           out_res
);

    localparam int PTR_W = $clog2(WINDOW_BYTES);
    localparam int CW    = $clog2(OUT_DEPTH + 1);

    logic              act_reg;
    op_t               op_reg;
    logic [7:0]        val_reg;
    logic [CNT_W-1:0]  left_reg;
    logic [PTR_W-1:0]  src_reg;
    logic              done_reg;
    logic [1:0]        err_reg;
    logic [PTR_W-1:0]  wptr_reg;

    logic              b_valid_reg;
    logic              b_ram_reg;
    logic [7:0]        b_val_reg;
    logic              b_last_reg;
    logic              b_done_reg;
    logic [1:0]        b_err_reg;
    logic [PTR_W-1:0]  b_addr_reg;
    logic              byp_hit_reg;
    logic [7:0]        byp_data_reg;

    logic [7:0]        ram_rdata;
    logic [7:0]        b_data;
    logic              we;
    logic              space;
    logic              issue;
    logic              is_copy;

    assign cmd_pop = !act_reg && !cmd_empty;
    assign space   = ({1'b0, out_count} + (CW + 1)'(b_valid_reg)) < (CW + 1)'(OUT_DEPTH);
    assign issue   = act_reg && space;
    assign is_copy = (op_reg == OP_COPY);
    assign b_data  = b_ram_reg ? (byp_hit_reg ? byp_data_reg : ram_rdata) : b_val_reg;
    assign we      = b_valid_reg && (b_err_reg == ERR_NONE);

    assign out_push     = b_valid_reg;
    assign out_res.data = b_data;
    assign out_res.last = b_last_reg;
    assign out_res.done = b_done_reg;
    assign out_res.err  = b_err_reg;

    blzss_ram #(
        .WIDTH(8),
        .DEPTH(WINDOW_BYTES)
    ) u_history (
        .clk  (clk),
        .we   (we),
        .waddr(b_addr_reg),
        .wdata(b_data),
        .raddr(src_reg),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg     <= 1'b0;
            left_reg    <= '0;
            wptr_reg    <= '0;
            b_valid_reg <= 1'b0;
            b_ram_reg   <= 1'b0;
            byp_hit_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= issue;
            b_ram_reg   <= issue && is_copy;
            byp_hit_reg <= issue && is_copy && we && (src_reg == b_addr_reg);
            if (cmd_pop)
            begin
                act_reg  <= 1'b1;
                left_reg <= (cmd_head.op == OP_ERR) ? CNT_W'(1) : cmd_head.count;
            end
            else if (issue)
            begin
                left_reg <= left_reg - 1'b1;
                if (left_reg == CNT_W'(1))
                begin
                    act_reg <= 1'b0;
                end
                if (op_reg != OP_ERR)
                begin
                    wptr_reg <= wptr_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            op_reg   <= cmd_head.op;
            val_reg  <= (cmd_head.op == OP_ERR) ? 8'd0 : cmd_head.value;
            src_reg  <= wptr_reg - PTR_W'(cmd_head.dist_m1) - 1'b1;
            done_reg <= cmd_head.done;
            err_reg  <= cmd_head.err;
        end
        else if (issue && is_copy)
        begin
            src_reg <= src_reg + 1'b1;
        end
        b_val_reg    <= val_reg;
        b_last_reg   <= (left_reg == CNT_W'(1));
        b_done_reg   <= done_reg;
        b_err_reg    <= err_reg;
        b_addr_reg   <= wptr_reg;
        byp_data_reg <= b_data;
    end

endmodule

// ===== hw/rtl/blocked_lzss_stream_decoder.sv =====
// Decodes a blocked LZSS container presented one byte per word on the input queue and
// delivers the decoded bytes, one per word, on the output queue. A front stage parses
// the size and block headers, flag bytes and match words at one input byte per clock
// while its command queue has room; a back stage loads each command and then turns it
// into output bytes at one byte per clock through the history RAM while the output
// queue has room. A match yields 3 to 34 bytes, and the back stage loads no new
// command until the current one has issued its last byte. The history
// holds no reset contents and needs no clearing pass, so the block takes input right
// after reset. Error results carry run_last set and a zero byte; after a byte with
// in_last set the decoder starts over with a new stream.
module blocked_lzss_stream_decoder
    import blzss_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_BYTES_DEF,
    parameter int CMD_DEPTH    = CMD_DEPTH_DEF,
    parameter int OUT_DEPTH    = OUT_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       stream_done,
    output logic [1:0] error_code
);

    localparam int CMD_W = $bits(cmd_t);
    localparam int RES_W = $bits(res_t);

    logic                           accept;
    logic                           cmd_push;
    cmd_t                           cmd_in;
    cmd_t                           cmd_head;
    logic [CMD_W-1:0]               cmd_head_bits;
    logic                           cmd_pop;
    logic                           cmd_empty;
    logic                           cmd_full;
    logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
    logic                           out_push;
    res_t                           out_res;
    res_t                           res_head;
    logic [RES_W-1:0]               res_head_bits;
    logic                           out_full;
    logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

    assign full     = cmd_full;
    assign accept   = push && !cmd_full;
    assign cmd_head = cmd_t'(cmd_head_bits);
    assign res_head = res_t'(res_head_bits);

    assign out_byte    = res_head.data;
    assign run_last    = res_head.last;
    assign stream_done = res_head.done;
    assign error_code  = res_head.err;

    blzss_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .in_last (in_last),
        .cmd_push(cmd_push),
        .cmd     (cmd_in)
    );

    blzss_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_data(cmd_in),
        .rd_en  (cmd_pop),
        .rd_data(cmd_head_bits),
        .full   (cmd_full),
        .empty  (cmd_empty),
        .count  (cmd_count)
    );

    blzss_back #(
        .WINDOW_BYTES(WINDOW_BYTES),
        .OUT_DEPTH   (OUT_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_empty(cmd_empty),
        .cmd_head (cmd_head),
        .cmd_pop  (cmd_pop),
        .out_count(out_count),
        .out_push (out_push),
        .out_res  (out_res)
    );

    blzss_fifo #(
        .WIDTH(RES_W),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (out_push),
        .wr_data(out_res),
        .rd_en  (pop),
        .rd_data(res_head_bits),
        .full   (out_full),
        .empty  (empty),
        .count  (out_count)
    );

    // The back stage reserves output space before it reads history.
    a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result pushed into a full output queue");

    a_cmd_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> (cmd_count < ($clog2(CMD_DEPTH+1))'(CMD_DEPTH)))
        else $error("command pushed into a full command queue");

    a_err_word_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && error_code != ERR_NONE) |-> (run_last && out_byte == 8'd0))
        else $error("error word without run_last or with a nonzero byte");

    a_early_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && error_code == ERR_EARLY_END) |-> !stream_done)
        else $error("early-end error reported with stream_done set");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import blzss_pkg::*;

    localparam int NUM_DIRECTED = 27;
    localparam int RANDOM_ITEMS = 180;
    localparam int MAX_CYCLES   = 500000;

    typedef enum logic [3:0] {
        ST_SIZE0,
        ST_SIZE1,
        ST_SIZE2,
        ST_SIZE3,
        ST_HDR_HI,
        ST_HDR_LO,
        ST_STORED,
        ST_TOKEN,
        ST_AFTER_FLAG,
        ST_MATCH_LO,
        ST_DONE
    } parse_st_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       pinned;
        res_t       want;
    } stim_row_t;

    // Stream A: stored block, empty block, one-byte block, match before block start,
    // overflow of the declared size, then a word after completion.
    // Stream B: declared size of zero ending the stream silently.
    // Stream C: a stream that ends on its first size byte.
    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h07, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'h02, 1'b0, 1'b0, '0},
        '{8'hff, 1'b0, 1'b1, '{8'hff, 1'b1, 1'b0, ERR_NONE}},
        '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, ERR_NONE}},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h06, 1'b0, 1'b0, '0},
        '{8'h05, 1'b0, 1'b0, '0},
        '{8'hff, 1'b0, 1'b0, '0},
        '{8'he0, 1'b0, 1'b0, '0},
        '{8'hab, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h1f, 1'b0, 1'b0, '0},
        '{8'h5a, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, ERR_AFTER_DONE}},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},
        '{8'h12, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0, ERR_EARLY_END}}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;
    logic [1:0] error_code;

    blocked_lzss_stream_decoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .stream_done (stream_done),
        .error_code  (error_code)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stim_row_t  stim_q[$];
    res_t       expected_words[$];
    logic [7:0] run_bytes[$];
    int         cur_row = 0;
    int         next_row = 0;
    int         sent_cnt = 0;
    int         fail_cnt = 0;
    int         cycles = 0;

    logic [7:0]  hist_mem [0:2047];
    logic [7:0]  blk_first;
    logic [15:0] blk_pos;
    logic [15:0] flag_sr;
    parse_st_t   phase;
    logic [14:0] blk_left;
    logic [31:0] declared_size;
    logic [31:0] emitted;
    logic [7:0]  hold;

    task automatic reset_decoder();
        blk_first = 8'h00;
        blk_pos = 16'h0000;
        flag_sr = 16'h0000;
        phase = ST_SIZE0;
        blk_left = '0;
        declared_size = '0;
        emitted = '0;
        hold = 8'h00;
    endtask

    task automatic emit_byte(input logic [7:0] b);
        if (blk_pos == 16'h0000)
            blk_first = b;
        if (blk_pos != 16'hffff)
            blk_pos++;
        if (emitted < declared_size)
        begin
            hist_mem[emitted[10:0]] = b;
            emitted++;
            run_bytes.push_back(b);
        end
    endtask

    task automatic end_block();
        phase = (emitted >= declared_size) ? ST_DONE : ST_HDR_HI;
    endtask

    task automatic take_token(input logic [7:0] b);
        if (flag_sr[0])
        begin
            hold = b;
            phase = ST_MATCH_LO;
        end
        else
        begin
            emit_byte(b);
            phase = ST_TOKEN;
        end
    endtask

    task automatic copy_match(input logic [7:0] lo);
        logic [15:0] word;
        int unsigned len;
        int unsigned back_dist;
        logic [31:0] src;
        logic [7:0]  b;
        bit          before_start;
        word = {hold, lo};
        len = word[4:0] + 3;
        back_dist = word[15:5] + 1;
        before_start = back_dist > blk_pos;
        src = emitted - back_dist;
        for (int unsigned k = 0; k < len; k++)
        begin
            if (before_start)
                b = blk_first;
            else
            begin
                b = hist_mem[src[10:0]];
                src++;
            end
            emit_byte(b);
        end
        phase = ST_TOKEN;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [1:0]  err;
        logic [15:0] hdr;
        res_t        word;
        err = ERR_NONE;
        run_bytes.delete();
        if (phase == ST_DONE)
            err = ERR_AFTER_DONE;
        else if (phase <= ST_SIZE3)
        begin
            declared_size = {declared_size[23:0], b};
            if (phase == ST_SIZE3)
            begin
                emitted = '0;
                phase = (declared_size == 0) ? ST_DONE : ST_HDR_HI;
            end
            else
                phase = parse_st_t'(phase + 1);
        end
        else if (phase == ST_HDR_HI)
        begin
            hold = b;
            phase = ST_HDR_LO;
        end
        else if (phase == ST_HDR_LO)
        begin
            hdr = {hold, b};
            blk_left = hdr[14:0];
            blk_pos = 16'h0000;
            blk_first = 8'h00;
            flag_sr = 16'h0000;
            phase = hdr[15] ? ST_STORED : ST_TOKEN;
            if (blk_left == 0)
                end_block();
        end
        else
        begin
            case (phase)
                ST_STORED:
                    emit_byte(b);
                ST_TOKEN:
                begin
                    flag_sr = flag_sr >> 1;
                    if (!flag_sr[8])
                    begin
                        flag_sr = {8'hff, b};
                        phase = ST_AFTER_FLAG;
                    end
                    else
                        take_token(b);
                end
                ST_AFTER_FLAG:
                    take_token(b);
                default:
                    copy_match(b);
            endcase
            blk_left--;
            if (blk_left == 0)
                end_block();
        end

        if (err == ERR_NONE && last && phase != ST_DONE)
            err = ERR_EARLY_END;

        if (err != ERR_NONE)
        begin
            word.data = 8'h00;
            word.last = 1'b1;
            word.done = (err == ERR_AFTER_DONE);
            word.err = err;
            expected_words.push_back(word);
        end
        else
        begin
            foreach (run_bytes[k])
            begin
                word.data = run_bytes[k];
                word.last = (k == run_bytes.size() - 1);
                word.done = (phase == ST_DONE);
                word.err = ERR_NONE;
                expected_words.push_back(word);
            end
        end

        if (last)
            reset_decoder();
    endtask

    // Builds one container. Match distances either point before the block start or
    // stay within bytes already written in this stream, so no stale history is read.
    task automatic build_stream();
        logic [7:0]  body[$];
        logic [7:0]  flags;
        logic [15:0] word;
        logic [31:0] target;
        stim_row_t   row;
        int          r;
        int          made;
        int          emit_cnt;
        int          pos;
        int          nblk;
        int          kind;
        int          len;
        int          ntok;
        int          hdr_at;
        int          flag_at;
        int          blen;
        int          back_dist;
        int          mlen;
        int          cap;
        int          cut_at;
        int          t;
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(6, 1))
                body.push_back(8'($urandom));
        end
        else
        begin
            r = $urandom_range(19);
            target = (r == 0) ? 0 : (r < 16) ? $urandom_range(30, 1) : $urandom_range(120, 31);
            body.push_back(target[31:24]);
            body.push_back(target[23:16]);
            body.push_back(target[15:8]);
            body.push_back(target[7:0]);
            made = 0;
            nblk = 0;
            while (made < target && nblk < 12)
            begin
                nblk++;
                kind = $urandom_range(9);
                if (kind == 0)
                begin
                    body.push_back($urandom_range(1) ? 8'h80 : 8'h00);
                    body.push_back(8'h00);
                end
                else if (kind == 1)
                begin
                    body.push_back(8'h00);
                    body.push_back(8'h01);
                    body.push_back(8'($urandom));
                end
                else if (kind <= 4)
                begin
                    len = $urandom_range(8, 1);
                    body.push_back(8'h80);
                    body.push_back(8'(len));
                    repeat (len)
                        body.push_back(8'($urandom));
                    made += len;
                end
                else
                begin
                    ntok = $urandom_range(12, 1);
                    hdr_at = body.size();
                    body.push_back(8'h00);
                    body.push_back(8'h00);
                    blen = 0;
                    pos = 0;
                    flags = 8'h00;
                    flag_at = 0;
                    for (t = 0; t < ntok; t++)
                    begin
                        if (t % 8 == 0)
                        begin
                            flags = 8'($urandom);
                            flag_at = body.size();
                            body.push_back(flags);
                            blen++;
                        end
                        if (flags[t % 8])
                        begin
                            emit_cnt = (made < target) ? made : target;
                            cap = (pos < emit_cnt) ? pos : emit_cnt;
                            if (cap == 0 || $urandom_range(4) == 0)
                                back_dist = $urandom_range(2048, pos + 1);
                            else
                                back_dist = $urandom_range(cap, 1);
                            if ($urandom_range(7) == 0)
                                mlen = $urandom_range(34, 3);
                            else
                                mlen = $urandom_range(8, 3);
                            word = {11'(back_dist - 1), 5'(mlen - 3)};
                            body.push_back(word[15:8]);
                            body.push_back(word[7:0]);
                            blen += 2;
                            made += mlen;
                            pos += mlen;
                        end
                        else
                        begin
                            body.push_back(8'($urandom));
                            blen++;
                            made++;
                            pos++;
                        end
                    end
                    if ($urandom_range(5) == 0)
                    begin
                        if (ntok % 8 != 0)
                        begin
                            flags[ntok % 8] = 1'b1;
                            body[flag_at] = flags;
                        end
                        body.push_back(8'($urandom));
                        blen++;
                    end
                    body[hdr_at] = 8'(blen >> 8);
                    body[hdr_at + 1] = 8'(blen);
                end
            end
            if ($urandom_range(3) == 0)
            begin
                repeat ($urandom_range(2, 1))
                    body.push_back(8'($urandom));
            end
        end
        if ($urandom_range(7) == 0 && body.size() > 1)
        begin
            cut_at = $urandom_range(body.size() - 1, 1);
            while (body.size() > cut_at)
                void'(body.pop_back());
        end
        foreach (body[k])
        begin
            row = '0;
            row.data = body[k];
            row.last = (k == body.size() - 1);
            stim_q.push_back(row);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_cnt++;
        end
    endtask

    task automatic check_word();
        res_t want;
        if (expected_words.size() == 0)
        begin
            $error("output word with none expected: out_byte %0h, error_code %0d",
                   out_byte, error_code);
            fail_cnt++;
        end
        else
        begin
            want = expected_words.pop_front();
            check_field("out_byte", want.data, out_byte);
            check_field("run_last", 8'(want.last), 8'(run_last));
            check_field("stream_done", 8'(want.done), 8'(stream_done));
            check_field("error_code", 8'(want.err), 8'(error_code));
        end
    endtask

    always @(posedge clk)
    begin : sender
        int stage;
        int idle_pct;
        int n_before;
        if (rst_n)
        begin
            if (push && !full)
            begin
                n_before = expected_words.size();
                decode_byte(stim_q[cur_row].data, stim_q[cur_row].last);
                if (stim_q[cur_row].pinned)
                begin
                    while (expected_words.size() > n_before)
                        void'(expected_words.pop_back());
                    expected_words.push_back(stim_q[cur_row].want);
                end
                sent_cnt++;
            end
            stage = sent_cnt * 3 / stim_q.size();
            idle_pct = (stage == 0) ? 17 : (stage == 1) ? 78 : 0;
            if (push && full)
            begin
                push <= 1'b1;
            end
            else if (next_row < stim_q.size() && $urandom_range(99) >= idle_pct)
            begin
                cur_row = next_row;
                next_row++;
                in_byte <= stim_q[cur_row].data;
                in_last <= stim_q[cur_row].last;
                push <= 1'b1;
            end
            else
                push <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : receiver
        int stage;
        int idle_pct;
        if (rst_n)
        begin
            if (pop && !empty)
                check_word();
            stage = sent_cnt * 3 / stim_q.size();
            idle_pct = (stage == 0) ? 78 : (stage == 1) ? 17 : 0;
            pop <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("blocked_lzss_stream_decoder regression: fail");
            $finish;
        end
    end

    initial
    begin
        reset_decoder();
        foreach (DIRECTED_ROWS[k])
            stim_q.push_back(DIRECTED_ROWS[k]);
        while (stim_q.size() < NUM_DIRECTED + RANDOM_ITEMS)
            build_stream();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        while (!(sent_cnt == stim_q.size() && expected_words.size() == 0))
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_cnt == 0)
            $display("blocked_lzss_stream_decoder regression: pass");
        else
            $display("blocked_lzss_stream_decoder regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/blzss_pkg.sv
hw/rtl/blzss_ram.sv
hw/rtl/blzss_fifo.sv
hw/rtl/blzss_front.sv
hw/rtl/blzss_back.sv
hw/rtl/blocked_lzss_stream_decoder.sv
dv/tb_top.sv
